FILE: src/assert_macros.svh
// Assertion macros used by the RTL of the dirty-rectangle tile enumerator.
// No dependencies; included by the top file, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/drte_pkg.sv
// Package for the dirty-rectangle tile enumerator: widths, register codes,
// item and control structs, and rectangle helper functions. No dependencies.
package drte_pkg;

  localparam int COORD_W       = 16;
  localparam int SIZE_W        = 13;
  localparam int BORDER_W      = 8;
  localparam int IDX_W         = 3;
  localparam int MAX_GRID_SIDE = 8;
  localparam int OFS_W         = COORD_W + 1;
  localparam int CELL_W        = COORD_W + 3;
  localparam int DIV_CNT_W     = $clog2(OFS_W + 1);
  localparam int PADDR_W       = 4;
  localparam int PDATA_W       = 32;
  localparam int REG_IDX_W     = 2;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BORDER_SIZE = 2'd2;

  localparam logic [SIZE_W-1:0]   TILE_WIDTH_RST  = SIZE_W'(256);
  localparam logic [SIZE_W-1:0]   TILE_HEIGHT_RST = SIZE_W'(256);
  localparam logic [BORDER_W-1:0] BORDER_SIZE_RST = '0;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  typedef struct packed {
    logic   request_valid;
    coord_t dirty_left;
    coord_t dirty_top;
    coord_t dirty_right;
    coord_t dirty_bottom;
    coord_t scene_left;
    coord_t scene_top;
    coord_t scene_right;
    coord_t scene_bottom;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] tile_column;
    logic [IDX_W-1:0] tile_row;
    coord_t           phys_left;
    coord_t           phys_top;
    coord_t           phys_right;
    coord_t           phys_bottom;
    coord_t           patch_left;
    coord_t           patch_top;
    coord_t           patch_right;
    coord_t           patch_bottom;
    logic             last_tile;
    logic             grid_overflow;
  } tile_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   tile_width;
    logic [SIZE_W-1:0]   tile_height;
    logic [BORDER_W-1:0] border_size;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [OFS_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [OFS_W-1:0]  quotient;
    logic [SIZE_W-1:0] remainder;
  } div_res_t;

  // A rectangle is empty when its edges cross.
  function automatic logic rect_empty(input rect_t a);
    return (a.left > a.right) || (a.top > a.bottom);
  endfunction

  // Intersection of two rectangles.
  function automatic rect_t rect_and(input rect_t a, input rect_t b);
    rect_t o;
    o.left   = (a.left > b.left)     ? a.left   : b.left;
    o.top    = (a.top > b.top)       ? a.top    : b.top;
    o.right  = (a.right < b.right)   ? a.right  : b.right;
    o.bottom = (a.bottom < b.bottom) ? a.bottom : b.bottom;
    return o;
  endfunction

  // Low edge moved out by the border, then held at the limit.
  function automatic coord_t grow_lo(input coord_t a, input logic [BORDER_W-1:0] bd,
                                     input coord_t lim);
    logic signed [OFS_W-1:0] g;
    logic signed [OFS_W-1:0] l;
    g = OFS_W'(a) - OFS_W'(bd);
    l = OFS_W'(lim);
    return (g > l) ? g[COORD_W-1:0] : lim;
  endfunction

  // High edge moved out by the border, then held at the limit.
  function automatic coord_t grow_hi(input coord_t a, input logic [BORDER_W-1:0] bd,
                                     input coord_t lim);
    logic signed [OFS_W-1:0] g;
    logic signed [OFS_W-1:0] l;
    g = OFS_W'(a) + OFS_W'(bd);
    l = OFS_W'(lim);
    return (g < l) ? g[COORD_W-1:0] : lim;
  endfunction

  // Rectangle grown by the border on every side and clipped to a bound.
  function automatic rect_t grow_clip(input rect_t a, input logic [BORDER_W-1:0] bd,
                                      input rect_t lim);
    rect_t o;
    o.left   = grow_lo(a.left, bd, lim.left);
    o.top    = grow_lo(a.top, bd, lim.top);
    o.right  = grow_hi(a.right, bd, lim.right);
    o.bottom = grow_hi(a.bottom, bd, lim.bottom);
    return o;
  endfunction

  // Distance from a base edge to an edge that never lies below it.
  function automatic logic [OFS_W-1:0] offset(input coord_t a, input coord_t base);
    return OFS_W'(a) - OFS_W'(base);
  endfunction

endpackage

FILE: src/dirty_rect_tile_enumerator.sv
// Dirty-rectangle tile enumerator. A request is taken only while the block is
// idle and is then worked on alone. Setup has one step to clip the dirty
// rectangle, one to grow it, and four divisions through a single restoring
// divider that produces one of 17 quotient bits per cycle. Each visited tile
// then takes an effective and a physical step, held while the output is
// stalled, on a grid of at most 8 x 8 tiles; a closing step delivers the final
// item. A request that yields no item returns to idle from the clip step or
// the closing step without delivering an item.
// Depends on drte_pkg, drte_divider, drte_cfg_regs, drte_tile_eval.
`include "assert_macros.svh"

module dirty_rect_tile_enumerator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  drte_pkg::req_t                req,
  output logic                          tile_valid,
  input  logic                          tile_stall,
  output drte_pkg::tile_t               tile,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drte_pkg::PADDR_W-1:0]  paddr,
  input  logic [drte_pkg::PDATA_W-1:0]  pwdata,
  output logic [drte_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_CLIP      = 9'b000000010,
    S_GROW      = 9'b000000100,
    S_DIV       = 9'b000001000,
    S_DIV_WAIT  = 9'b000010000,
    S_LOOP_INIT = 9'b000100000,
    S_TILE_EFF  = 9'b001000000,
    S_TILE_PHYS = 9'b010000000,
    S_FINISH    = 9'b100000000
  } state_t;

  // Which of the four range divisions is in flight.
  localparam logic [1:0] DIV_FC = 2'd0;
  localparam logic [1:0] DIV_LC = 2'd1;
  localparam logic [1:0] DIV_FR = 2'd2;
  localparam logic [1:0] DIV_LR = 2'd3;

  localparam int IW = drte_pkg::IDX_W;
  localparam int CW = drte_pkg::CELL_W;

  state_t state, state_next;

  drte_pkg::cfg_t     cfg;
  drte_pkg::div_req_t div_req;
  drte_pkg::div_res_t div_res;

  logic [drte_pkg::SIZE_W-1:0] tw_eff;
  logic [drte_pkg::SIZE_W-1:0] th_eff;

  drte_pkg::rect_t dirty, scene, upd, grown, upd_new;
  drte_pkg::rect_t eff, phys, patch;
  logic            eff_empty, patch_empty;

  logic [1:0]                  div_idx;
  logic [IW-1:0]               fc_cap, lc_cap, fr_cap, lr_cap;
  logic                        fc_over, fr_over, ovf;
  logic [drte_pkg::SIZE_W-1:0] rem_c, rem_r;
  logic [IW-1:0]               q_cap;
  logic                        q_over;

  logic [IW-1:0]         col, row;
  logic signed [CW-1:0]  col_left, row_top, row_top0;
  logic signed [CW-1:0]  tw_cell, th_cell, cell_r, cell_b;
  logic signed [CW-1:0]  scn_l, scn_t, scn_r, scn_b;
  logic signed [CW-1:0]  eff_l, eff_t, eff_r, eff_b;
  logic                  eff_empty_new;

  drte_pkg::tile_t pend;
  logic            pend_valid;
  drte_pkg::tile_t tile_d;
  drte_pkg::tile_t tile_q;

  logic out_free, out_load, out_last, pend_load, advance;
  logic at_row_end, at_col_end;

  logic ovf_shown, in_walk, walk_ok, drain_now, drained;

  // Configuration registers.
  drte_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A tile size of zero behaves as one.
  assign tw_eff = (cfg.tile_width == '0)  ? drte_pkg::SIZE_W'(1) : cfg.tile_width;
  assign th_eff = (cfg.tile_height == '0) ? drte_pkg::SIZE_W'(1) : cfg.tile_height;

  // Shared divider and its operand selection.
  always_comb begin
    div_req.start = (state == S_DIV);
    case (div_idx)
      DIV_FC:  div_req.dividend = drte_pkg::offset(grown.left, scene.left);
      DIV_LC:  div_req.dividend = drte_pkg::offset(grown.right, scene.left);
      DIV_FR:  div_req.dividend = drte_pkg::offset(grown.top, scene.top);
      default: div_req.dividend = drte_pkg::offset(grown.bottom, scene.top);
    endcase
    div_req.divisor = div_idx[1] ? th_eff : tw_eff;
  end

  drte_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  // Quotient held to the grid cap.
  assign q_over = div_res.quotient >= drte_pkg::OFS_W'(drte_pkg::MAX_GRID_SIDE);
  assign q_cap  = q_over ? IW'(drte_pkg::MAX_GRID_SIDE - 1) : div_res.quotient[IW-1:0];

  // Update rectangle: the dirty area inside the scene.
  assign upd_new = drte_pkg::rect_and(dirty, scene);

  // Effective tile cell: the grid cell intersected with the scene.
  always_comb begin
    tw_cell = CW'(tw_eff);
    th_cell = CW'(th_eff);
    cell_r  = col_left + tw_cell - CW'(1);
    cell_b  = row_top + th_cell - CW'(1);
    scn_l   = CW'(scene.left);
    scn_t   = CW'(scene.top);
    scn_r   = CW'(scene.right);
    scn_b   = CW'(scene.bottom);
    eff_l   = (col_left > scn_l) ? col_left : scn_l;
    eff_t   = (row_top > scn_t)  ? row_top  : scn_t;
    eff_r   = (cell_r < scn_r)   ? cell_r   : scn_r;
    eff_b   = (cell_b < scn_b)   ? cell_b   : scn_b;
    eff_empty_new = (eff_l > eff_r) || (eff_t > eff_b);
  end

  // Physical rectangle and patch of the current tile.
  drte_tile_eval u_eval (
    .eff         (eff),
    .scene       (scene),
    .upd         (upd),
    .bd          (cfg.border_size),
    .phys        (phys),
    .patch       (patch),
    .patch_empty (patch_empty)
  );

  assign out_free   = !tile_valid || !tile_stall;
  assign at_row_end = (row == lr_cap);
  assign at_col_end = (col == lc_cap);
  assign req_stall  = (state != S_IDLE);

  // Sequencer. One found tile waits in the pending register until the next
  // one, or the end of the request, decides whether it is the last item.
  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    out_last   = 1'b0;
    pend_load  = 1'b0;
    advance    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid && req.request_valid) state_next = S_CLIP;
      end
      S_CLIP: begin
        if (drte_pkg::rect_empty(dirty) || drte_pkg::rect_empty(scene) ||
            drte_pkg::rect_empty(upd_new)) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_GROW;
        end
      end
      S_GROW: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_res.done) state_next = (div_idx == DIV_LR) ? S_LOOP_INIT : S_DIV;
      end
      S_LOOP_INIT: begin
        state_next = (fc_over || fr_over) ? S_FINISH : S_TILE_EFF;
      end
      S_TILE_EFF: begin
        state_next = S_TILE_PHYS;
      end
      S_TILE_PHYS: begin
        if (eff_empty || patch_empty) begin
          advance = 1'b1;
        end else if (!pend_valid || out_free) begin
          pend_load = 1'b1;
          out_load  = pend_valid;
          advance   = 1'b1;
        end
        if (advance) state_next = (at_row_end && at_col_end) ? S_FINISH : S_TILE_EFF;
      end
      S_FINISH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      tile_valid <= 1'b0;
    end else begin
      state      <= state_next;
      tile_valid <= out_load || (tile_valid && tile_stall);
      if (pend_load) begin
        pend_valid <= 1'b1;
      end else if (out_last) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Request capture, clipping and growth.
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      dirty <= '{left: req.dirty_left, top: req.dirty_top,
                 right: req.dirty_right, bottom: req.dirty_bottom};
      scene <= '{left: req.scene_left, top: req.scene_top,
                 right: req.scene_right, bottom: req.scene_bottom};
    end
    if (state == S_CLIP) upd <= upd_new;
    if (state == S_GROW) grown <= drte_pkg::grow_clip(upd, cfg.border_size, scene);
  end

  // Division results: column and row ranges, with the remainders that place
  // the first cell.
  always_ff @(posedge clk) begin
    if (state == S_GROW) begin
      div_idx <= DIV_FC;
    end else if (state == S_DIV_WAIT && div_res.done) begin
      div_idx <= div_idx + 1'b1;
      case (div_idx)
        DIV_FC: begin
          fc_cap  <= q_cap;
          fc_over <= q_over;
          rem_c   <= div_res.remainder;
        end
        DIV_LC: begin
          lc_cap <= q_cap;
          ovf    <= q_over;
        end
        DIV_FR: begin
          fr_cap  <= q_cap;
          fr_over <= q_over;
          rem_r   <= div_res.remainder;
        end
        default: begin
          lr_cap <= q_cap;
          ovf    <= ovf || q_over;
        end
      endcase
    end
  end

  // Tile walk: columns outside, rows inside; cell corners step by the tile size.
  always_ff @(posedge clk) begin
    if (state == S_LOOP_INIT) begin
      col      <= fc_cap;
      row      <= fr_cap;
      col_left <= CW'(grown.left) - CW'(rem_c);
      row_top  <= CW'(grown.top) - CW'(rem_r);
      row_top0 <= CW'(grown.top) - CW'(rem_r);
    end else if (advance) begin
      if (!at_row_end) begin
        row     <= row + 1'b1;
        row_top <= row_top + th_cell;
      end else begin
        col      <= col + 1'b1;
        col_left <= col_left + tw_cell;
        row      <= fr_cap;
        row_top  <= row_top0;
      end
    end
    if (state == S_TILE_EFF) begin
      eff.left   <= eff_l[drte_pkg::COORD_W-1:0];
      eff.top    <= eff_t[drte_pkg::COORD_W-1:0];
      eff.right  <= eff_r[drte_pkg::COORD_W-1:0];
      eff.bottom <= eff_b[drte_pkg::COORD_W-1:0];
      eff_empty  <= eff_empty_new;
    end
  end

  // Outgoing item: the pending tile with its end mark and overflow flag.
  always_comb begin
    tile_d               = pend;
    tile_d.last_tile     = out_last;
    tile_d.grid_overflow = out_last && ovf;
  end

  // Pending tile and output register.
  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend.tile_column   <= col;
      pend.tile_row      <= row;
      pend.phys_left     <= phys.left;
      pend.phys_top      <= phys.top;
      pend.phys_right    <= phys.right;
      pend.phys_bottom   <= phys.bottom;
      pend.patch_left    <= patch.left;
      pend.patch_top     <= patch.top;
      pend.patch_right   <= patch.right;
      pend.patch_bottom  <= patch.bottom;
      pend.last_tile     <= 1'b0;
      pend.grid_overflow <= 1'b0;
    end
    if (out_load) tile_q <= tile_d;
  end

  assign tile = tile_q;

  // Conditions named for the checks below.
  assign ovf_shown = tile_valid && tile.grid_overflow;
  assign in_walk   = (state == S_TILE_EFF);
  assign walk_ok   = (col <= lc_cap) && (row <= lr_cap);
  assign drain_now = (state == S_FINISH) && pend_valid && out_free;
  assign drained   = !pend_valid && tile_valid && tile.last_tile;

  // Checks on the sequencer and the shared divider.
  `ASSERT_IMP(a_ovf_only_last, clk, rst, ovf_shown, tile.last_tile, "overflow on a non-final item")
  `ASSERT_IMP(a_walk_in_range, clk, rst, in_walk, walk_ok, "tile walk outside its range")
  `ASSERT_IMP(a_div_start_idle, clk, rst, div_req.start, !div_res.busy, "divider busy at start")
  `ASSERT_NEXT(a_final_drain, clk, rst, drain_now, drained, "final item not delivered")

endmodule

FILE: src/drte_divider.sv
// Restoring divider shared by the four grid-range divisions, one quotient bit
// per cycle. Depends on drte_pkg.
module drte_divider (
  input  logic               clk,
  input  logic               rst,
  input  drte_pkg::div_req_t req,
  output drte_pkg::div_res_t res
);

  logic                              busy;
  logic                              done;
  logic [drte_pkg::DIV_CNT_W-1:0]    count;
  logic [drte_pkg::OFS_W-1:0]        quo;
  logic [drte_pkg::SIZE_W-1:0]       rem;
  logic [drte_pkg::SIZE_W-1:0]       dvs;
  logic [drte_pkg::SIZE_W:0]         partial;
  logic [drte_pkg::SIZE_W:0]         diff;
  logic                              fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    partial = {rem, quo[drte_pkg::OFS_W-1]};
    diff    = partial - {1'b0, dvs};
    fits    = partial >= {1'b0, dvs};
  end

  // Control: start loads the unit, done pulses after the last quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= drte_pkg::DIV_CNT_W'(drte_pkg::OFS_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == drte_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      quo <= {quo[drte_pkg::OFS_W-2:0], fits};
      rem <= fits ? diff[drte_pkg::SIZE_W-1:0] : partial[drte_pkg::SIZE_W-1:0];
    end
  end

  assign res.busy      = busy;
  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

FILE: src/drte_cfg_regs.sv
// Configuration registers of the tile enumerator behind an APB-style port.
// Depends on drte_pkg.
module drte_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drte_pkg::PADDR_W-1:0]  paddr,
  input  logic [drte_pkg::PDATA_W-1:0]  pwdata,
  output logic [drte_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output drte_pkg::cfg_t                cfg
);

  logic                             wr_en;
  logic [drte_pkg::REG_IDX_W-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[drte_pkg::PADDR_W-1:2];

  // Register writes; an address past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_width  <= drte_pkg::TILE_WIDTH_RST;
      cfg.tile_height <= drte_pkg::TILE_HEIGHT_RST;
      cfg.border_size <= drte_pkg::BORDER_SIZE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        drte_pkg::REG_TILE_WIDTH:  cfg.tile_width  <= pwdata[drte_pkg::SIZE_W-1:0];
        drte_pkg::REG_TILE_HEIGHT: cfg.tile_height <= pwdata[drte_pkg::SIZE_W-1:0];
        drte_pkg::REG_BORDER_SIZE: cfg.border_size <= pwdata[drte_pkg::BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      drte_pkg::REG_TILE_WIDTH:  prdata = drte_pkg::PDATA_W'(cfg.tile_width);
      drte_pkg::REG_TILE_HEIGHT: prdata = drte_pkg::PDATA_W'(cfg.tile_height);
      drte_pkg::REG_BORDER_SIZE: prdata = drte_pkg::PDATA_W'(cfg.border_size);
      default:                   prdata = '0;
    endcase
  end

endmodule

FILE: src/drte_tile_eval.sv
// Per-tile geometry: physical rectangle from the effective tile rectangle and
// its patch against the update rectangle. Depends on drte_pkg.
module drte_tile_eval (
  input  drte_pkg::rect_t              eff,
  input  drte_pkg::rect_t              scene,
  input  drte_pkg::rect_t              upd,
  input  logic [drte_pkg::BORDER_W-1:0] bd,
  output drte_pkg::rect_t              phys,
  output drte_pkg::rect_t              patch,
  output logic                         patch_empty
);

  // Grow the tile by the border, keep it in the scene, then cut to the update area.
  always_comb begin
    phys        = drte_pkg::grow_clip(eff, bd, scene);
    patch       = drte_pkg::rect_and(phys, upd);
    patch_empty = drte_pkg::rect_empty(patch);
  end

endmodule
